// ===== design/arc_pkg.sv =====
// shared types, constants and arithmetic helpers of the adaptive rate controller
package arc_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [1:0] op_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // operation codes
  localparam op_t OP_MODEL = 2'd0;
  localparam op_t OP_REF = 2'd1;
  localparam op_t OP_SAMPLE = 2'd2;

  // register indexes
  localparam cfg_idx_t CFG_GAIN_X = 3'd0;
  localparam cfg_idx_t CFG_GAIN_R = 3'd1;
  localparam cfg_idx_t CFG_GAIN_J = 3'd2;
  localparam cfg_idx_t CFG_LYAP = 3'd3;
  localparam cfg_idx_t CFG_LEAK_GAIN = 3'd4;
  localparam cfg_idx_t CFG_LEAK_QUAD = 3'd5;

  // register reset values
  localparam cfg_t RST_GAIN_X = 31'd655360000;
  localparam cfg_t RST_GAIN_R = 31'd655360000;
  localparam cfg_t RST_GAIN_J = 31'd65536;
  localparam cfg_t RST_LYAP = 31'd327680;
  localparam cfg_t RST_LEAK_GAIN = 31'd327680;
  localparam cfg_t RST_LEAK_QUAD = 31'd32768;

  // gain memory: per row 3 state gains, 3 reference gains, 6 quadratic gains
  localparam int ROW_LEN = 12;
  localparam int GAIN_DEPTH = 36;
  localparam int GAIN_AW = 6;
  localparam data_t GAIN_DIAG = data_t'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam data_t GAIN_TINY = data_t'(((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000);

  // quaternion scaling window
  localparam logic [31:0] QSCALE_LO = 32'd1 << 13;
  localparam logic [31:0] QSCALE_HI = 32'd1 << 14;

  // saturating add
  function automatic data_t sat_add(data_t a, data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  // saturating subtract
  function automatic data_t sat_sub(data_t a, data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  // magnitude of a signed word
  function automatic logic [DATA_W-1:0] mag(data_t a);
    return a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  endfunction

endpackage

// ===== design/arc_in_if.sv =====
// input channel of the adaptive rate controller
interface arc_in_if;
  import arc_pkg::*;

  logic valid;
  logic ready;
  op_t op;
  data_t vec_x;
  data_t vec_y;
  data_t vec_z;
  data_t quat_w;
  data_t quat_x;
  data_t quat_y;
  data_t quat_z;
  cfg_t step_time;

  modport source(output valid, op, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                 step_time, input ready);
  modport sink(input valid, op, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
               step_time, output ready);
endinterface

// ===== design/arc_out_if.sv =====
// result channel of the adaptive rate controller
interface arc_out_if;
  import arc_pkg::*;

  logic valid;
  logic ready;
  data_t torque_x;
  data_t torque_y;
  data_t torque_z;
  data_t body_rate_x;
  data_t body_rate_y;
  data_t body_rate_z;
  data_t model_out_x;
  data_t model_out_y;
  data_t model_out_z;

  modport source(output valid, torque_x, torque_y, torque_z, body_rate_x, body_rate_y,
                 body_rate_z, model_out_x, model_out_y, model_out_z, input ready);
  modport sink(input valid, torque_x, torque_y, torque_z, body_rate_x, body_rate_y,
               body_rate_z, model_out_x, model_out_y, model_out_z, output ready);
endinterface

// ===== design/adaptive_rate_controller.sv =====
// Three-axis model reference adaptive rate controller, signed Q16.16.
// Channels: in_ch carries one transaction per command; op selects loading the
// model state, loading the reference command, or a sensor sample
// (world rate, attitude quaternion, step time). out_ch carries one result per
// sample after the first: saturated torque, body-frame rate and model state.
// Loads and the first sample produce no result. A later sample goes through
// quaternion scaling (up to 18 shifts), 10 quaternion products, the matrix
// step, three 3-term rotation sums each followed by a 34-step restoring
// division, 18 products for error, quadratic terms and row factors, then a
// read-modify-write of each of the 36 gain memory entries with torque
// accumulation. A zero quaternion skips the rotation and keeps the rate.
// One shared 32x32 multiplier with a rounding stage serves all products; the
// gain memory has one read and one write port. Samples are processed one at
// a time; in_ch.ready returns in the cycle the result appears.
// Reset loads register defaults and runs a pass that writes the gain reset
// values; in_ch.ready stays low during it. A result waits in an output
// register while the receiver stalls; new loads are still taken, and a
// finished sample holds until the output register frees up.
module adaptive_rate_controller (
  input  logic                        clk,
  input  logic                        rst,
  arc_in_if.sink                      in_ch,
  arc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  arc_pkg::cfg_idx_t           cfg_index,
  input  arc_pkg::cfg_t               cfg_data
);
  import arc_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_QPR  = 4'd3;
  localparam logic [3:0] S_MAT  = 4'd4;
  localparam logic [3:0] S_ROT  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_PE   = 4'd7;
  localparam logic [3:0] S_F    = 4'd8;
  localparam logic [3:0] S_G    = 4'd9;
  localparam logic [3:0] S_RD   = 4'd10;
  localparam logic [3:0] S_GRAD = 4'd11;
  localparam logic [3:0] S_LEAK = 4'd12;
  localparam logic [3:0] S_DT   = 4'd13;
  localparam logic [3:0] S_TQ   = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0] state;
  logic [1:0] row;
  logic [3:0] col;
  logic       phase;
  logic [5:0] step;

  cfg_t gain_x, gain_r, gain_j, lyap_weight, leak_gain, leak_quad;
  logic started;
  data_t ms [3];
  data_t rc [3];

  data_t vin [3];
  logic [31:0] qm [4];
  logic qs [4];
  cfg_t dt;

  data_t prods [10];
  data_t rm [9];
  logic [30:0] nrm;
  logic signed [63:0] sacc;
  logic [30:0] rem;
  logic [33:0] dreg;
  logic [33:0] quot;
  logic sneg;

  data_t x [3];
  data_t pe [3];
  data_t f [6];
  data_t gx [3];
  data_t gr [3];
  data_t gj [3];
  data_t k_r, grad, dd, knew, acc;
  data_t torque [3];

  logic out_valid;
  data_t o_t [3];
  data_t o_b [3];
  data_t o_m [3];

  logic [63:0] prod;
  logic pneg;
  data_t mul_a, mul_b;
  data_t qv;
  logic signed [63:0] rawp;

  logic ram_we;
  logic [GAIN_AW-1:0] ram_addr;
  data_t ram_wdata;
  data_t ram_rdata;

  logic in_acc;
  logic [31:0] big;
  data_t opnd, gsel, lsel, upd_sum;
  data_t qsig [4];
  logic signed [63:0] snext;
  logic [63:0] smag, dnum;
  logic [31:0] dtry;
  logic dge;
  logic [33:0] quot_next;
  data_t x_div;
  logic [3:0] rm_idx;
  data_t acc_next;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  // gain memory
  arc_ram #(.WIDTH(DATA_W), .DEPTH(GAIN_DEPTH)) u_gain_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_addr),
    .wdata(ram_wdata),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  assign ram_addr = GAIN_AW'({row, 3'b000}) + GAIN_AW'({row, 2'b00}) + GAIN_AW'(col);
  assign ram_we = (state == S_INIT) || (state == S_DT && phase);
  assign upd_sum = sat_add(k_r, qv);

  // init values or updated gain
  always_comb begin
    if (state == S_INIT) begin
      if (col < 4'd6) begin
        ram_wdata = ((col == 4'(row)) || (col == 4'(row) + 4'd3)) ? GAIN_DIAG : '0;
      end else begin
        ram_wdata = GAIN_TINY;
      end
    end else begin
      ram_wdata = upd_sum;
    end
  end

  // quaternion scale and sign
  always_comb begin
    big = qm[0];
    for (int i = 1; i < 4; i++) begin
      if (qm[i] > big) begin
        big = qm[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      qsig[i] = qs[i] ? data_t'(-qm[i]) : data_t'(qm[i]);
    end
  end

  // update operand selection by column
  always_comb begin
    case (col)
      4'd0, 4'd1, 4'd2: begin
        opnd = x[col[1:0]];
        gsel = gx[row];
        lsel = data_t'({1'b0, leak_gain});
      end
      4'd3: begin opnd = rc[0]; gsel = gr[row]; lsel = data_t'({1'b0, leak_gain}); end
      4'd4: begin opnd = rc[1]; gsel = gr[row]; lsel = data_t'({1'b0, leak_gain}); end
      4'd5: begin opnd = rc[2]; gsel = gr[row]; lsel = data_t'({1'b0, leak_gain}); end
      4'd6: begin opnd = f[0]; gsel = gj[row]; lsel = data_t'({1'b0, leak_quad}); end
      4'd7: begin opnd = f[1]; gsel = gj[row]; lsel = data_t'({1'b0, leak_quad}); end
      4'd8: begin opnd = f[2]; gsel = gj[row]; lsel = data_t'({1'b0, leak_quad}); end
      4'd9: begin opnd = f[3]; gsel = gj[row]; lsel = data_t'({1'b0, leak_quad}); end
      4'd10: begin opnd = f[4]; gsel = gj[row]; lsel = data_t'({1'b0, leak_quad}); end
      default: begin opnd = f[5]; gsel = gj[row]; lsel = data_t'({1'b0, leak_quad}); end
    endcase
  end

  assign rm_idx = 4'({col[1:0], 1'b0}) + 4'(col[1:0]) + 4'(row);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_QPR: begin
        case (col)
          4'd0: begin mul_a = qsig[0]; mul_b = qsig[0]; end
          4'd1: begin mul_a = qsig[1]; mul_b = qsig[1]; end
          4'd2: begin mul_a = qsig[2]; mul_b = qsig[2]; end
          4'd3: begin mul_a = qsig[3]; mul_b = qsig[3]; end
          4'd4: begin mul_a = qsig[1]; mul_b = qsig[2]; end
          4'd5: begin mul_a = qsig[0]; mul_b = qsig[3]; end
          4'd6: begin mul_a = qsig[1]; mul_b = qsig[3]; end
          4'd7: begin mul_a = qsig[0]; mul_b = qsig[2]; end
          4'd8: begin mul_a = qsig[2]; mul_b = qsig[3]; end
          default: begin mul_a = qsig[0]; mul_b = qsig[1]; end
        endcase
      end
      S_ROT: begin
        mul_a = rm[rm_idx];
        mul_b = vin[col[1:0]];
      end
      S_PE: begin
        mul_a = data_t'({1'b0, lyap_weight});
        mul_b = sat_sub(x[row], ms[row]);
      end
      S_F: begin
        case (col)
          4'd0: begin mul_a = x[0]; mul_b = x[0]; end
          4'd1: begin mul_a = x[1]; mul_b = x[1]; end
          4'd2: begin mul_a = x[2]; mul_b = x[2]; end
          4'd3: begin mul_a = x[0]; mul_b = x[1]; end
          4'd4: begin mul_a = x[0]; mul_b = x[2]; end
          default: begin mul_a = x[1]; mul_b = x[2]; end
        endcase
      end
      S_G: begin
        mul_b = pe[row];
        case (col)
          4'd0: mul_a = data_t'({1'b0, gain_x});
          4'd1: mul_a = data_t'({1'b0, gain_r});
          default: mul_a = data_t'({1'b0, gain_j});
        endcase
      end
      S_GRAD: begin mul_a = gsel; mul_b = opnd; end
      S_LEAK: begin mul_a = lsel; mul_b = k_r; end
      S_DT: begin mul_a = data_t'({1'b0, dt}); mul_b = dd; end
      S_TQ: begin mul_a = knew; mul_b = opnd; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // round to nearest, ties away, saturate
  always_comb begin
    logic [63:0] lo2;
    logic [47:0] q;
    logic [47:0] lim;
    lo2 = prod + (64'd1 << (FRAC_BITS - 1));
    q = lo2[63:FRAC_BITS];
    lim = pneg ? (48'd1 << (DATA_W - 1)) : ((48'd1 << (DATA_W - 1)) - 48'd1);
    if (q > lim) begin
      q = lim;
    end
    qv = pneg ? data_t'(-q[DATA_W-1:0]) : data_t'(q[DATA_W-1:0]);
    rawp = pneg ? $signed(64'd0 - prod) : $signed(prod);
  end

  // rotation sum, divider step
  always_comb begin
    snext = ((col == 4'd0) ? 64'sd0 : sacc) + rawp;
    smag = snext[63] ? 64'(-snext) : 64'(snext);
    dnum = smag + 64'({1'b0, nrm[30:1]});
    dtry = {rem, dreg[33]};
    dge = dtry >= {1'b0, nrm};
    quot_next = {quot[32:0], dge};
    if (sneg) begin
      x_div = (quot_next > (34'd1 << 31)) ? {1'b1, 31'd0} : data_t'(-quot_next[31:0]);
    end else begin
      x_div = (quot_next > ((34'd1 << 31) - 34'd1)) ? {1'b0, {31{1'b1}}}
                                                     : data_t'(quot_next[31:0]);
    end
    acc_next = sat_add((col == 4'd0) ? data_t'(0) : acc, qv);
  end

  // shared multiplier stage
  always_ff @(posedge clk) begin
    prod <= mag(mul_a) * mag(mul_b);
    pneg <= mul_a[DATA_W-1] ^ mul_b[DATA_W-1];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x <= RST_GAIN_X;
      gain_r <= RST_GAIN_R;
      gain_j <= RST_GAIN_J;
      lyap_weight <= RST_LYAP;
      leak_gain <= RST_LEAK_GAIN;
      leak_quad <= RST_LEAK_QUAD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_X: gain_x <= cfg_data;
        CFG_GAIN_R: gain_r <= cfg_data;
        CFG_GAIN_J: gain_j <= cfg_data;
        CFG_LYAP: lyap_weight <= cfg_data;
        CFG_LEAK_GAIN: leak_gain <= cfg_data;
        CFG_LEAK_QUAD: leak_quad <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && !(out_valid && !out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (state == S_OUT && !(out_valid && !out_ch.ready)) begin
      for (int i = 0; i < 3; i++) begin
        o_t[i] <= torque[i];
        o_b[i] <= x[i];
        o_m[i] <= ms[i];
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.torque_x = o_t[0];
  assign out_ch.torque_y = o_t[1];
  assign out_ch.torque_z = o_t[2];
  assign out_ch.body_rate_x = o_b[0];
  assign out_ch.body_rate_y = o_b[1];
  assign out_ch.body_rate_z = o_b[2];
  assign out_ch.model_out_x = o_m[0];
  assign out_ch.model_out_y = o_m[1];
  assign out_ch.model_out_z = o_m[2];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      row <= '0;
      col <= '0;
      phase <= 1'b0;
      step <= '0;
      started <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        ms[i] <= '0;
        rc[i] <= '0;
        x[i] <= '0;
      end
    end else begin
      case (state)
        // write gain reset values
        S_INIT: begin
          if (col == 4'(ROW_LEN - 1)) begin
            col <= '0;
            if (row == 2'd2) begin
              row <= '0;
              state <= S_IDLE;
            end else begin
              row <= row + 2'd1;
            end
          end else begin
            col <= col + 4'd1;
          end
        end
        // take a transaction
        S_IDLE: begin
          if (in_acc) begin
            case (in_ch.op)
              OP_MODEL: begin
                ms[0] <= in_ch.vec_x; ms[1] <= in_ch.vec_y; ms[2] <= in_ch.vec_z;
              end
              OP_REF: begin
                rc[0] <= in_ch.vec_x; rc[1] <= in_ch.vec_y; rc[2] <= in_ch.vec_z;
              end
              OP_SAMPLE: begin
                if (!started) begin
                  started <= 1'b1;
                end else begin
                  vin[0] <= in_ch.vec_x; vin[1] <= in_ch.vec_y; vin[2] <= in_ch.vec_z;
                  qm[0] <= mag(in_ch.quat_w); qs[0] <= in_ch.quat_w[DATA_W-1];
                  qm[1] <= mag(in_ch.quat_x); qs[1] <= in_ch.quat_x[DATA_W-1];
                  qm[2] <= mag(in_ch.quat_y); qs[2] <= in_ch.quat_y[DATA_W-1];
                  qm[3] <= mag(in_ch.quat_z); qs[3] <= in_ch.quat_z[DATA_W-1];
                  dt <= in_ch.step_time;
                  state <= S_NORM;
                end
              end
              default: ;
            endcase
          end
        end
        // scale quaternion into the working window, or bypass rotation for a zero quaternion
        S_NORM: begin
          if (big == '0) begin
            for (int i = 0; i < 3; i++) begin
              x[i] <= vin[i];
            end
            row <= '0;
            phase <= 1'b0;
            state <= S_PE;
          end else if (big >= QSCALE_HI) begin
            for (int i = 0; i < 4; i++) begin
              qm[i] <= qm[i] >> 1;
            end
          end else if (big < QSCALE_LO) begin
            for (int i = 0; i < 4; i++) begin
              qm[i] <= qm[i] << 1;
            end
          end else begin
            col <= '0;
            phase <= 1'b0;
            state <= S_QPR;
          end
        end
        // quaternion pair products
        S_QPR: begin
          phase <= !phase;
          if (phase) begin
            prods[col] <= rawp[31:0];
            if (col == 4'd9) begin
              state <= S_MAT;
            end else begin
              col <= col + 4'd1;
            end
          end
        end
        // rotation matrix scaled by the norm
        S_MAT: begin
          rm[0] <= prods[0] + prods[1] - prods[2] - prods[3];
          rm[1] <= (prods[4] - prods[5]) <<< 1;
          rm[2] <= (prods[6] + prods[7]) <<< 1;
          rm[3] <= (prods[4] + prods[5]) <<< 1;
          rm[4] <= prods[0] - prods[1] + prods[2] - prods[3];
          rm[5] <= (prods[8] - prods[9]) <<< 1;
          rm[6] <= (prods[6] - prods[7]) <<< 1;
          rm[7] <= (prods[8] + prods[9]) <<< 1;
          rm[8] <= prods[0] - prods[1] - prods[2] + prods[3];
          nrm <= 31'(prods[0] + prods[1] + prods[2] + prods[3]);
          row <= '0;
          col <= '0;
          phase <= 1'b0;
          state <= S_ROT;
        end
        // column sum of one body component
        S_ROT: begin
          phase <= !phase;
          if (phase) begin
            sacc <= snext;
            if (col == 4'd2) begin
              sneg <= snext[63];
              rem <= 31'(dnum[63:34]);
              dreg <= dnum[33:0];
              quot <= '0;
              step <= '0;
              state <= S_DIV;
            end else begin
              col <= col + 4'd1;
            end
          end
        end
        // restoring division by the norm, one quotient bit a cycle
        S_DIV: begin
          rem <= dge ? 31'(dtry - {1'b0, nrm}) : dtry[30:0];
          dreg <= {dreg[32:0], 1'b0};
          quot <= quot_next;
          step <= step + 6'd1;
          if (step == 6'd33) begin
            x[row] <= x_div;
            col <= '0;
            phase <= 1'b0;
            if (row == 2'd2) begin
              row <= '0;
              state <= S_PE;
            end else begin
              row <= row + 2'd1;
              state <= S_ROT;
            end
          end
        end
        // weighted tracking error
        S_PE: begin
          phase <= !phase;
          if (phase) begin
            pe[row] <= qv;
            if (row == 2'd2) begin
              col <= '0;
              state <= S_F;
            end else begin
              row <= row + 2'd1;
            end
          end
        end
        // quadratic rate terms
        S_F: begin
          phase <= !phase;
          if (phase) begin
            f[col[2:0]] <= qv;
            if (col == 4'd5) begin
              col <= '0;
              row <= '0;
              state <= S_G;
            end else begin
              col <= col + 4'd1;
            end
          end
        end
        // per-row adaptation factors
        S_G: begin
          phase <= !phase;
          if (phase) begin
            case (col)
              4'd0: gx[row] <= qv;
              4'd1: gr[row] <= qv;
              default: gj[row] <= qv;
            endcase
            if (col == 4'd2) begin
              col <= '0;
              if (row == 2'd2) begin
                row <= '0;
                state <= S_RD;
              end else begin
                row <= row + 2'd1;
              end
            end else begin
              col <= col + 4'd1;
            end
          end
        end
        // read gain entry
        S_RD: begin
          phase <= 1'b0;
          state <= S_GRAD;
        end
        // gradient term
        S_GRAD: begin
          phase <= !phase;
          if (!phase) begin
            k_r <= ram_rdata;
          end else begin
            grad <= qv;
            state <= S_LEAK;
          end
        end
        // leakage term
        S_LEAK: begin
          phase <= !phase;
          if (phase) begin
            dd <= sat_sub(sat_sub('0, grad), qv);
            state <= S_DT;
          end
        end
        // time step, write back
        S_DT: begin
          phase <= !phase;
          if (phase) begin
            knew <= upd_sum;
            state <= S_TQ;
          end
        end
        // torque accumulation
        S_TQ: begin
          phase <= !phase;
          if (phase) begin
            acc <= acc_next;
            if (col == 4'(ROW_LEN - 1)) begin
              torque[row] <= acc_next;
              col <= '0;
              if (row == 2'd2) begin
                row <= '0;
                state <= S_OUT;
              end else begin
                row <= row + 2'd1;
                state <= S_RD;
              end
            end else begin
              col <= col + 4'd1;
              state <= S_RD;
            end
          end
        end
        // hand result to output register
        S_OUT: begin
          if (!(out_valid && !out_ch.ready)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an accepted sample leaves the loop armed
  a_first_sample: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.op == OP_SAMPLE) |=> started)
    else $error("sample did not arm the loop");

  // results come only once the loop is armed
  a_result_armed: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(started))
    else $error("result before the first sample");

  // divider remainder stays below the norm
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < nrm))
    else $error("divider remainder out of range");

  // gain writes only from init pass or update step
  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != S_INIT) |-> ($past(state) == S_DT && !$past(phase)))
    else $error("unexpected gain memory write");

endmodule

// ===== design/arc_ram.sv =====
// generic single write port ram with registered read
module arc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== dv/adaptive_rate_controller_test.sv =====
// testbench of the adaptive rate controller: random and directed commands checked against a predictor
`timescale 1ns / 1ps

module adaptive_rate_controller_test;
  import arc_pkg::*;

  typedef longint signed s64;
  typedef longint unsigned u64;

  localparam op_t OP_UNUSED = 2'd3;
  localparam int CFG_NUM = 6;
  localparam int DRAIN_CYCLES = 600;
  localparam data_t WORD_MIN = 32'sh8000_0000;
  localparam data_t WORD_MAX = 32'sh7fff_ffff;
  localparam cfg_t CFG_MAX = 31'h7fff_ffff;

  typedef struct packed {
    op_t op;
    data_t vec_x, vec_y, vec_z;
    data_t quat_w, quat_x, quat_y, quat_z;
    cfg_t step_time;
  } command_t;

  typedef struct packed {
    data_t torque_x, torque_y, torque_z;
    data_t body_rate_x, body_rate_y, body_rate_z;
    data_t model_out_x, model_out_y, model_out_z;
  } control_t;

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_idx_t cfg_index;
  cfg_t cfg_data;

  arc_in_if in_ch();
  arc_out_if out_ch();

  adaptive_rate_controller DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // controller state mirrored by the predictor
  s64 ctl_cfg[CFG_NUM];
  s64 mdl_state[3];
  s64 ref_cmd[3];
  s64 kx[9];
  s64 kr[9];
  s64 kq[18];
  bit loop_started;

  command_t pending_cmds[$];
  control_t expected_ctl[$];
  int idle_pct;
  int stall_pct;
  int errors;
  int sent_count;
  int checked_count;
  int sample_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // saturation to the word range
  function automatic s64 sat_w(s64 r);
    if (r > 64'sd2147483647) return 64'sd2147483647;
    if (r < -64'sd2147483648) return -64'sd2147483648;
    return r;
  endfunction

  // fixed point product, rounded half away from zero, saturated
  function automatic s64 fx_mul(s64 a, s64 b);
    u64 ma, mb, p, lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = a < 0 ? u64'(-a) : u64'(a);
    mb = b < 0 ? u64'(-b) : u64'(b);
    p = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? (64'd1 << 31) : (64'd1 << 31) - 1;
    if (p > lim) p = lim;
    return neg ? -s64'(p) : s64'(p);
  endfunction

  // leaky gradient step of one gain entry
  function automatic s64 leaky_step(s64 k, s64 grad, s64 leak, s64 dt);
    s64 d;
    d = sat_w(sat_w(-grad) - fx_mul(leak, k));
    return sat_w(k + fx_mul(dt, d));
  endfunction

  // world rate rotated into the body frame by the normalized quaternion
  function automatic void body_frame(input command_t c, output s64 r[3]);
    s64 v[3], q[4], rm[3][3], n, s, w, a, b, z;
    u64 m[4], big, ms, qt;
    bit sg[4];
    v[0] = s64'(c.vec_x); v[1] = s64'(c.vec_y); v[2] = s64'(c.vec_z);
    q[0] = s64'(c.quat_w); q[1] = s64'(c.quat_x);
    q[2] = s64'(c.quat_y); q[3] = s64'(c.quat_z);
    big = 0;
    for (int i = 0; i < 4; i++) begin
      sg[i] = q[i] < 0;
      m[i] = q[i] < 0 ? u64'(-q[i]) : u64'(q[i]);
      if (m[i] > big) big = m[i];
    end
    // zero quaternion leaves the rate untouched
    if (big == 0) begin
      for (int i = 0; i < 3; i++) r[i] = v[i];
      return;
    end
    while (big >= (64'd1 << 14)) begin
      big = big >> 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
    end
    while (big < (64'd1 << 13)) begin
      big = big << 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 4; i++) q[i] = sg[i] ? -s64'(m[i]) : s64'(m[i]);
    w = q[0]; a = q[1]; b = q[2]; z = q[3];
    n = w*w + a*a + b*b + z*z;
    rm[0][0] = w*w + a*a - b*b - z*z;
    rm[0][1] = 2 * (a*b - w*z);
    rm[0][2] = 2 * (a*z + w*b);
    rm[1][0] = 2 * (a*b + w*z);
    rm[1][1] = w*w - a*a + b*b - z*z;
    rm[1][2] = 2 * (b*z - w*a);
    rm[2][0] = 2 * (a*z - w*b);
    rm[2][1] = 2 * (b*z + w*a);
    rm[2][2] = w*w - a*a - b*b + z*z;
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += rm[j][i] * v[j];
      ms = s < 0 ? u64'(-s) : u64'(s);
      qt = (ms + u64'(n) / 2) / u64'(n);
      r[i] = sat_w(s < 0 ? -s64'(qt) : s64'(qt));
    end
  endfunction

  // restore controller state after reset
  function automatic void reset_controller();
    for (int i = 0; i < 3; i++) begin
      mdl_state[i] = 0;
      ref_cmd[i] = 0;
    end
    for (int i = 0; i < 9; i++) begin
      kx[i] = (i % 4 == 0) ? s64'(GAIN_DIAG) : 0;
      kr[i] = (i % 4 == 0) ? s64'(GAIN_DIAG) : 0;
    end
    for (int i = 0; i < 18; i++) kq[i] = s64'(GAIN_TINY);
    loop_started = 1'b0;
    ctl_cfg[CFG_GAIN_X] = RST_GAIN_X;
    ctl_cfg[CFG_GAIN_R] = RST_GAIN_R;
    ctl_cfg[CFG_GAIN_J] = RST_GAIN_J;
    ctl_cfg[CFG_LYAP] = RST_LYAP;
    ctl_cfg[CFG_LEAK_GAIN] = RST_LEAK_GAIN;
    ctl_cfg[CFG_LEAK_QUAD] = RST_LEAK_QUAD;
  endfunction

  // apply one command; returns 1 with the control output when a sample closes the loop
  function automatic bit control_update(input command_t c, output control_t res);
    s64 x[3], pe[3], f[6], acc[3], dt, gx, gr, gj;
    res = '0;
    case (c.op)
      OP_MODEL: begin
        mdl_state[0] = c.vec_x; mdl_state[1] = c.vec_y; mdl_state[2] = c.vec_z;
        return 0;
      end
      OP_REF: begin
        ref_cmd[0] = c.vec_x; ref_cmd[1] = c.vec_y; ref_cmd[2] = c.vec_z;
        return 0;
      end
      OP_UNUSED: return 0;
      default: ;
    endcase
    if (!loop_started) begin
      loop_started = 1'b1;
      return 0;
    end
    dt = s64'(c.step_time);
    body_frame(c, x);
    for (int i = 0; i < 3; i++)
      pe[i] = fx_mul(ctl_cfg[CFG_LYAP], sat_w(x[i] - mdl_state[i]));
    f[0] = fx_mul(x[0], x[0]);
    f[1] = fx_mul(x[1], x[1]);
    f[2] = fx_mul(x[2], x[2]);
    f[3] = fx_mul(x[0], x[1]);
    f[4] = fx_mul(x[0], x[2]);
    f[5] = fx_mul(x[1], x[2]);
    // gain adaptation from the pre-update tracking error
    for (int i = 0; i < 3; i++) begin
      gx = fx_mul(ctl_cfg[CFG_GAIN_X], pe[i]);
      gr = fx_mul(ctl_cfg[CFG_GAIN_R], pe[i]);
      gj = fx_mul(ctl_cfg[CFG_GAIN_J], pe[i]);
      for (int j = 0; j < 3; j++) begin
        kx[i*3+j] = leaky_step(kx[i*3+j], fx_mul(gx, x[j]), ctl_cfg[CFG_LEAK_GAIN], dt);
        kr[i*3+j] = leaky_step(kr[i*3+j], fx_mul(gr, ref_cmd[j]),
                               ctl_cfg[CFG_LEAK_GAIN], dt);
      end
      for (int j = 0; j < 6; j++)
        kq[i*6+j] = leaky_step(kq[i*6+j], fx_mul(gj, f[j]), ctl_cfg[CFG_LEAK_QUAD], dt);
    end
    // torque from the updated gains
    for (int i = 0; i < 3; i++) begin
      acc[i] = 0;
      for (int j = 0; j < 3; j++) acc[i] = sat_w(acc[i] + fx_mul(kx[i*3+j], x[j]));
      for (int j = 0; j < 3; j++) acc[i] = sat_w(acc[i] + fx_mul(kr[i*3+j], ref_cmd[j]));
      for (int j = 0; j < 6; j++) acc[i] = sat_w(acc[i] + fx_mul(kq[i*6+j], f[j]));
    end
    res.torque_x = data_t'(acc[0]);
    res.torque_y = data_t'(acc[1]);
    res.torque_z = data_t'(acc[2]);
    res.body_rate_x = data_t'(x[0]);
    res.body_rate_y = data_t'(x[1]);
    res.body_rate_z = data_t'(x[2]);
    res.model_out_x = data_t'(mdl_state[0]);
    res.model_out_y = data_t'(mdl_state[1]);
    res.model_out_z = data_t'(mdl_state[2]);
    return 1;
  endfunction

  function automatic void check_field(string name, data_t exp_v, data_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        command_t c;
        c = pending_cmds.pop_front();
        in_ch.op <= c.op;
        in_ch.vec_x <= c.vec_x;
        in_ch.vec_y <= c.vec_y;
        in_ch.vec_z <= c.vec_z;
        in_ch.quat_w <= c.quat_w;
        in_ch.quat_x <= c.quat_x;
        in_ch.quat_y <= c.quat_y;
        in_ch.quat_z <= c.quat_z;
        in_ch.step_time <= c.step_time;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= $urandom_range(99) >= stall_pct;
  end

  // monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_ctl.size() == 0) begin
          $error("result transaction with no expectation pending");
          errors++;
        end else begin
          control_t e;
          e = expected_ctl.pop_front();
          check_field("torque_x", e.torque_x, out_ch.torque_x);
          check_field("torque_y", e.torque_y, out_ch.torque_y);
          check_field("torque_z", e.torque_z, out_ch.torque_z);
          check_field("body_rate_x", e.body_rate_x, out_ch.body_rate_x);
          check_field("body_rate_y", e.body_rate_y, out_ch.body_rate_y);
          check_field("body_rate_z", e.body_rate_z, out_ch.body_rate_z);
          check_field("model_out_x", e.model_out_x, out_ch.model_out_x);
          check_field("model_out_y", e.model_out_y, out_ch.model_out_y);
          check_field("model_out_z", e.model_out_z, out_ch.model_out_z);
          checked_count++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        command_t c;
        control_t r;
        c = '{in_ch.op, in_ch.vec_x, in_ch.vec_y, in_ch.vec_z, in_ch.quat_w,
              in_ch.quat_x, in_ch.quat_y, in_ch.quat_z, in_ch.step_time};
        sent_count++;
        if (c.op == OP_SAMPLE) sample_count++;
        if (control_update(c, r)) expected_ctl.push_back(r);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, cfg_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    ctl_cfg[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_cmds.size() > 0 || in_ch.valid || expected_ctl.size() > 0) @(negedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic command_t make_cmd(op_t op, data_t x, data_t y, data_t z,
                                        data_t qw, data_t qx, data_t qy, data_t qz,
                                        cfg_t dt);
    command_t c;
    c = '{op, x, y, z, qw, qx, qy, qz, dt};
    return c;
  endfunction

  // rate-like value: mostly moderate, sometimes extreme or fully random
  function automatic data_t rand_word();
    data_t pick[5];
    pick = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1, 32'sd1};
    case ($urandom_range(9))
      0, 1: return data_t'($urandom);
      2: return pick[$urandom_range(4)];
      3: return data_t'($urandom_range(1 << 22)) - data_t'(1 << 21);
      default: return data_t'($urandom_range(1 << 19)) - data_t'(1 << 18);
    endcase
  endfunction

  function automatic data_t rand_quat();
    if ($urandom_range(7) == 0) return data_t'($urandom);
    return data_t'($urandom_range(1 << 17)) - data_t'(1 << 16);
  endfunction

  function automatic cfg_t rand_dt();
    case ($urandom_range(9))
      0: return cfg_t'($urandom);
      1: return cfg_t'($urandom_range(1 << 16));
      default: return cfg_t'($urandom_range(6554));
    endcase
  endfunction

  function automatic command_t rand_cmd();
    command_t c;
    int sel;
    sel = $urandom_range(99);
    c.op = sel < 15 ? OP_MODEL : sel < 30 ? OP_REF : sel < 96 ? OP_SAMPLE : OP_UNUSED;
    c.vec_x = rand_word();
    c.vec_y = rand_word();
    c.vec_z = rand_word();
    if ($urandom_range(29) == 0) begin
      c.quat_w = 0; c.quat_x = 0; c.quat_y = 0; c.quat_z = 0;
    end else begin
      c.quat_w = rand_quat(); c.quat_x = rand_quat();
      c.quat_y = rand_quat(); c.quat_z = rand_quat();
    end
    c.step_time = rand_dt();
    return c;
  endfunction

  task automatic set_all_regs(cfg_t gx, cfg_t gr, cfg_t gj, cfg_t lyap, cfg_t lg, cfg_t lq);
    write_reg(CFG_GAIN_X, gx);
    write_reg(CFG_GAIN_R, gr);
    write_reg(CFG_GAIN_J, gj);
    write_reg(CFG_LYAP, lyap);
    write_reg(CFG_LEAK_GAIN, lg);
    write_reg(CFG_LEAK_QUAD, lq);
  endtask

  task automatic random_phase(int n);
    @(negedge clk);
    repeat (n) pending_cmds.push_back(rand_cmd());
    wait_idle();
  endtask

  // stimulus sequence
  initial begin
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    sample_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_GAIN_X;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_MODEL;
    in_ch.vec_x = '0; in_ch.vec_y = '0; in_ch.vec_z = '0;
    in_ch.quat_w = '0; in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0;
    in_ch.step_time = '0;
    out_ch.ready = 1'b0;
    reset_controller();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    repeat (40) @(posedge clk);

    // directed: first sample, unused op, extremes, zero and extreme quaternions
    @(negedge clk);
    pending_cmds.push_back(make_cmd(OP_SAMPLE, 32'sd65536, 0, 0, 32'sd65536, 0, 0, 0, 31'd655));
    pending_cmds.push_back(make_cmd(OP_UNUSED, WORD_MAX, WORD_MIN, 1, 1, 1, 1, 1, CFG_MAX));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, 32'sd65536, -32'sd65536, 32'sd32768,
                                    32'sd65536, 0, 0, 0, 31'd655));
    pending_cmds.push_back(make_cmd(OP_MODEL, WORD_MAX, WORD_MIN, -32'sd1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_REF, WORD_MIN, WORD_MAX, 32'sd1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, 32'sd131072, 32'sd65536, -32'sd65536,
                                    0, 0, 0, 0, 31'd0));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, WORD_MAX, WORD_MIN, WORD_MAX,
                                    WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 31'd1));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, WORD_MIN, WORD_MIN, WORD_MIN,
                                    WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, CFG_MAX));
    pending_cmds.push_back(make_cmd(OP_MODEL, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_REF, 32'sd65536, 32'sd65536, 32'sd65536, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, 32'sd1000, -32'sd2000, 32'sd3000,
                                    32'sd1, 0, 0, 0, 31'd6554));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, 32'sd1000, -32'sd2000, 32'sd3000,
                                    0, -32'sd1, 32'sd1, 0, 31'd6554));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, -32'sd1, 32'sd1, 0,
                                    32'sd46341, 32'sd46341, 0, 0, 31'd65536));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, 32'sd500000, 32'sd500000, -32'sd500000,
                                    32'sd16384, 32'sd8191, -32'sd8192, 32'sd16383, 31'd3000));
    pending_cmds.push_back(make_cmd(OP_SAMPLE, -32'sd70000, 32'sd90000, 32'sd10,
                                    -32'sd40000, 32'sd20000, -32'sd30000, 32'sd100,
                                    31'd6554));
    wait_idle();

    // no idling, register defaults written explicitly
    set_all_regs(RST_GAIN_X, RST_GAIN_R, RST_GAIN_J, RST_LYAP, RST_LEAK_GAIN, RST_LEAK_QUAD);
    random_phase(300);

    // sender idles half the time, all registers at their maximum
    idle_pct = 50;
    set_all_regs(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    random_phase(150);
    // registers at zero
    set_all_regs('0, '0, '0, '0, '0, '0);
    random_phase(150);

    // receiver stalls half the time, random settings
    idle_pct = 0;
    stall_pct = 50;
    set_all_regs(cfg_t'($urandom), cfg_t'($urandom_range(1 << 20)), cfg_t'($urandom_range(1 << 18)),
                 cfg_t'($urandom_range(1 << 19)), cfg_t'($urandom_range(1 << 19)),
                 cfg_t'($urandom));
    random_phase(300);

    // both sides idle, mild settings
    idle_pct = 14;
    stall_pct = 14;
    set_all_regs(31'd65536, 31'd6553600, 31'd32768, 31'd65536, 31'd655, 31'd6554);
    random_phase(300);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_ctl.size() > 0) begin
      $error("%0d expected results never arrived", expected_ctl.size());
      errors++;
    end
    $display("covered %0d commands (%0d samples), %0d control outputs checked",
             sent_count, sample_count, checked_count);
    $display("register settings: defaults, all maximum, all zero, random and mild");
    if (errors == 0) begin
      $display("PASS adaptive_rate_controller");
    end else begin
      $display("FAIL adaptive_rate_controller");
    end
    $finish;
  end

  // run limit
  initial begin
    #40ms;
    $display("FAIL adaptive_rate_controller");
    $finish;
  end

endmodule

// ===== files.f =====
design/arc_pkg.sv
design/arc_in_if.sv
design/arc_out_if.sv
design/arc_ram.sv
design/adaptive_rate_controller.sv
dv/adaptive_rate_controller_test.sv
